// ----- rtl/dlr_pkg.sv -----
package dlr_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 19;
  // working phase carries one extra bit for phase plus step before the wrap
  localparam int unsigned PHASE_W  = STEP_W + 1;
  localparam int unsigned MAX_OUT  = 4;
  localparam int unsigned CNT_W    = $clog2(MAX_OUT);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic emit;
    logic last;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic phase_ge_one;
    logic next_ge_one;
  } status_t;

endpackage

// ----- rtl/downmix_linear_resampler_unit.sv -----
// Linear-interpolation resampler with stereo downmix. Each input item is one
// 16-bit sample (tuser low) or a left/right pair (tuser high) that is averaged
// with truncation toward zero. A 4.16 phase (FRAC_BITS fraction bits) steps by
// the value written on the cfg channel (source rate << FRAC_BITS / mixer rate,
// steps below one quarter act as one quarter); while the phase is below one an
// output item prev + ((new - prev) * frac >>> FRAC_BITS) is produced, so one
// input gives zero to four outputs, tlast on the final one. Each output of an
// item passes the single 17 x FRAC_BITS multiplier (ST_MUL), then the add
// into the output register (ST_ADD), which waits while the previous output
// is not taken. The next input item is taken right after the last output is
// written, while that output still waits on m_axis_tready.
module downmix_linear_resampler_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // left_sample [15:0], right_sample [31:16]
  input  logic [0:0]  s_axis_tuser,  // stereo [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_sample [15:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [18:0] cfg_data_i     // phase_step
);

  dlr_pkg::cmd_t    cmd;
  dlr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  dlr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  dlr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (s_axis_tdata),
    .in_stereo_i  (s_axis_tuser[0]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ----- rtl/dlr_ctrl.sv -----
module dlr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  dlr_pkg::status_t status_i,
  output dlr_pkg::cmd_t    cmd_o
);

  dlr_pkg::state_e               state_q, state_d;
  logic [dlr_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_free;
  logic                          last_out;

  assign out_free = !out_valid_q || m_axis_tready;
  assign last_out = status_i.next_ge_one || (cnt_q == dlr_pkg::CNT_W'(dlr_pkg::MAX_OUT - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      dlr_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = dlr_pkg::ST_MUL;
        end
      end
      dlr_pkg::ST_MUL: begin
        if (status_i.phase_ge_one) begin
          state_d = dlr_pkg::ST_IDLE;
        end else begin
          state_d = dlr_pkg::ST_ADD;
        end
      end
      dlr_pkg::ST_ADD: begin
        if (out_free) begin
          state_d = last_out ? dlr_pkg::ST_IDLE : dlr_pkg::ST_MUL;
        end
      end
      default: state_d = dlr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    cnt_d         = cnt_q;
    case (state_q)
      dlr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
        if (s_axis_tvalid) begin
          cnt_d = '0;
        end
      end
      dlr_pkg::ST_MUL: begin
        // phase already at or above one: the item skips with no result
        cmd_o.mul    = !status_i.phase_ge_one;
        cmd_o.finish = status_i.phase_ge_one;
      end
      dlr_pkg::ST_ADD: begin
        if (out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.last   = last_out;
          cmd_o.finish = last_out;
          cnt_d        = cnt_q + 1'b1;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || m_axis_tready))
    else $error("result written over an item not yet taken");

  a_fourth_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cnt_q == dlr_pkg::CNT_W'(dlr_pkg::MAX_OUT - 1)) |-> cmd_o.last)
    else $error("more than four results for one item");

  a_load_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == dlr_pkg::ST_MUL))
    else $error("accepted item did not start");
`endif

endmodule

// ----- rtl/dlr_datapath.sv -----
module dlr_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlr_pkg::cmd_t                 cmd_i,
  output dlr_pkg::status_t              status_o,
  input  logic [2*dlr_pkg::SAMPLE_W-1:0] in_data_i,
  input  logic                          in_stereo_i,
  input  logic                          cfg_valid_i,
  input  logic [dlr_pkg::STEP_W-1:0]    cfg_data_i,
  output logic [dlr_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                          out_last_o
);

  localparam int unsigned SW = dlr_pkg::SAMPLE_W;
  localparam int unsigned PW = SW + 2 + FRAC_BITS;
  localparam logic [dlr_pkg::PHASE_W-1:0] PHASE_ONE = dlr_pkg::PHASE_W'(1) << FRAC_BITS;
  localparam logic [dlr_pkg::STEP_W-1:0]  STEP_MIN  = dlr_pkg::STEP_W'(1) << (FRAC_BITS - 2);

  logic [dlr_pkg::STEP_W-1:0]  step_q;
  logic [dlr_pkg::STEP_W-1:0]  step_eff;
  logic [SW-1:0]               prev_q, prev_d;
  logic [SW-1:0]               cur_q, cur_d;
  logic [dlr_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [dlr_pkg::PHASE_W-1:0] phase_next;
  logic [dlr_pkg::PHASE_W-1:0] phase_fin;
  logic signed [PW-1:0]        prod_q, prod_d;
  logic signed [PW-1:0]        prod_sh;
  logic [SW-1:0]               out_q, out_d;
  logic                        last_q;
  logic signed [SW:0]          pair_sum;
  logic signed [SW:0]          pair_half;
  logic signed [SW:0]          diff;

  // downmix, truncated toward zero
  assign pair_sum  = $signed({in_data_i[SW-1], in_data_i[SW-1:0]})
                   + $signed({in_data_i[2*SW-1], in_data_i[2*SW-1:SW]});
  assign pair_half = (pair_sum + $signed({{SW{1'b0}}, pair_sum[SW]})) >>> 1;
  assign cur_d     = in_stereo_i ? pair_half[SW-1:0] : in_data_i[SW-1:0];

  assign step_eff   = (step_q < STEP_MIN) ? STEP_MIN : step_q;
  assign phase_next = phase_q + {1'b0, step_eff};

  assign status_o.phase_ge_one = (phase_q >= PHASE_ONE);
  assign status_o.next_ge_one  = (phase_next >= PHASE_ONE);

  assign diff   = $signed({cur_q[SW-1], cur_q}) - $signed({prev_q[SW-1], prev_q});
  assign prod_d = $signed({{(PW-SW-1){diff[SW]}}, diff})
                * $signed({{(PW-FRAC_BITS){1'b0}}, phase_q[FRAC_BITS-1:0]});

  assign prod_sh = prod_q >>> FRAC_BITS;
  assign out_d   = prev_q + prod_sh[SW-1:0];

  assign phase_fin = (cmd_i.emit ? phase_next : phase_q) - PHASE_ONE;

  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    if (cmd_i.finish) begin
      phase_d = {1'b0, phase_fin[dlr_pkg::STEP_W-1:0]};
      prev_d  = cur_q;
    end else if (cmd_i.emit) begin
      phase_d = phase_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= dlr_pkg::STEP_RESET;
      prev_q  <= '0;
      phase_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end
      prev_q  <= prev_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= cur_d;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.emit) begin
      out_q  <= out_d;
      last_q <= cmd_i.last;
    end
  end

  assign out_sample_o = out_q;
  assign out_last_o   = last_q;

`ifndef SYNTH
  a_phase_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !phase_q[dlr_pkg::PHASE_W-1])
    else $error("stored phase out of range after an item");
`endif

endmodule
